// ===== design/sirs_pkg.sv =====
// Shared types and constants for the signed integer to radix symbol converter.
// Used by sirs_ctrl, sirs_dp and signed_int_to_radix_symbols; no dependencies.
package sirs_pkg;

  localparam int NUM_REGS    = 8;
  localparam int REG_W       = 64;
  localparam int REG_IDX_W   = 3;
  localparam int SYM_W       = 8;
  localparam int VALUE_W     = 32;
  localparam int ALPHA_IDX_W = 6;   // addresses the 64 alphabet bytes
  localparam int MAX_DIGITS  = 32;
  localparam int DIGIT_IDX_W = 5;
  localparam int ND_W        = 6;   // digit count, 0..32
  localparam int BIT_CNT_W   = 5;

  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CHAR_WS_LO = 8'd9;
  localparam logic [SYM_W-1:0] CHAR_WS_HI = 8'd13;
  localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

  // "01234567" and "89": decimal alphabet after reset
  localparam logic [REG_W-1:0] SYMS_RST_0 = 64'h3736_3534_3332_3130;
  localparam logic [REG_W-1:0] SYMS_RST_1 = 64'h0000_0000_0000_3938;

  typedef struct packed {
    logic load;        // capture value, clear scan and digit state
    logic scan;        // check one alphabet symbol
    logic div;         // one restoring division step
    logic emit_sign;   // send '-'
    logic emit_digit;  // send top digit of the stack
  } dp_cmd_t;

  typedef struct packed {
    logic sc_zero;     // terminator found at scan index
    logic sc_bad;      // symbol forbidden or repeated
    logic sc_last;     // scan index at last allowed symbol
    logic sc_short;    // scan index below 2
    logic bit_last;    // final step of the current digit
    logic q_zero;      // quotient after this step is zero
    logic neg;         // value was negative
    logic out_last;    // one digit left on the stack
  } dp_stat_t;

endpackage

// ===== design/sirs_ctrl.sv =====
// Sequencer for the radix converter: alphabet scan, digit division, emission.
// Depends on sirs_pkg; drives sirs_dp by command struct.
module sirs_ctrl import sirs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  // commands depend on the state (and start) only, never on datapath status
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
      end
      ST_SIGN: begin
        cmd_o.emit_sign = 1'b1;
      end
      ST_OUT: begin
        cmd_o.emit_digit = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.sc_bad) begin
          state_d = ST_IDLE;
        end else if (stat_i.sc_zero) begin
          state_d = stat_i.sc_short ? ST_IDLE : ST_DIV;
        end else if (stat_i.sc_last) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.bit_last && stat_i.q_zero) begin
          state_d = stat_i.neg ? ST_SIGN : ST_OUT;
        end
      end
      ST_SIGN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== design/sirs_dp.sv =====
// Datapath for the radix converter: alphabet registers, checker, bit-serial
// divider, digit stack and output register. Depends on sirs_pkg.
module sirs_dp import sirs_pkg::*; #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]    cfg_wdata_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  output logic [SYM_W-1:0]    symbol_o,
  output logic                last_o,
  output logic                strobe_o
);

  localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int RADIX_W = $clog2(MAX_SYMBOLS + 1);

  logic [REG_W-1:0]         syms_q [NUM_REGS];
  logic [DIGIT_W-1:0]       idx_q;
  logic [RADIX_W-1:0]       radix_q;
  logic [VALUE_W-1:0]       mag_q, mag_d;
  logic                     neg_q;
  logic [DIGIT_W-1:0]       rem_q, rem_d;
  logic [BIT_CNT_W-1:0]     bcnt_q;
  logic [DIGIT_W-1:0]       stack_q [MAX_DIGITS];
  logic [ND_W-1:0]          nd_q, nd_m1;
  logic [SYM_W-1:0]         sym_q;
  logic                     last_q, strobe_q;

  logic [DIGIT_W-1:0]       lk_idx;
  logic [ALPHA_IDX_W-1:0]   lk_ext;
  logic [REG_W-1:0]         lk_row;
  logic [SYM_W-1:0]         lk_byte;
  logic                     dup, forbid;
  logic [DIGIT_W:0]         trial, radix_ext;
  logic                     ge;

  assign nd_m1 = nd_q - 1'b1;

  // one lookup port: scan index during the check, stacked digit on output
  assign lk_idx  = cmd_i.scan ? idx_q : stack_q[nd_m1[DIGIT_IDX_W-1:0]];
  assign lk_ext  = ALPHA_IDX_W'(lk_idx);
  assign lk_row  = syms_q[lk_ext[ALPHA_IDX_W-1:3]];
  assign lk_byte = lk_row[lk_ext[2:0]*SYM_W +: SYM_W];

  assign forbid = (lk_byte == CHAR_MINUS) || (lk_byte == CHAR_PLUS) ||
                  (lk_byte == CHAR_SPACE) ||
                  ((lk_byte >= CHAR_WS_LO) && (lk_byte <= CHAR_WS_HI));

  // repeat check against every earlier symbol at once
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((DIGIT_W'(j) < idx_q) &&
          (syms_q[j / 8][(j % 8) * SYM_W +: SYM_W] == lk_byte)) begin
        dup = 1'b1;
      end
    end
  end

  // restoring division step, dividend bits enter MSB first
  assign radix_ext = (DIGIT_W + 1)'(radix_q);
  assign trial     = {rem_q, mag_q[VALUE_W-1]};
  assign ge        = (trial >= radix_ext);
  assign rem_d     = ge ? DIGIT_W'(trial - radix_ext) : trial[DIGIT_W-1:0];
  assign mag_d     = {mag_q[VALUE_W-2:0], ge};

  always_comb begin
    stat_o          = '0;
    stat_o.sc_zero  = (lk_byte == CHAR_NUL);
    stat_o.sc_bad   = (lk_byte != CHAR_NUL) && (forbid || dup);
    stat_o.sc_last  = (idx_q == DIGIT_W'(MAX_SYMBOLS - 1));
    stat_o.sc_short = ({1'b0, idx_q} < (DIGIT_W + 1)'(2));
    stat_o.bit_last = &bcnt_q;
    stat_o.q_zero   = (mag_d == '0);
    stat_o.neg      = neg_q;
    stat_o.out_last = (nd_q == ND_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        syms_q[r] <= (r == 0) ? SYMS_RST_0 : ((r == 1) ? SYMS_RST_1 : '0);
      end
      strobe_q  <= 1'b0;
      idx_q     <= '0;
      bcnt_q    <= '0;
      nd_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        syms_q[cfg_idx_i] <= cfg_wdata_i;
      end
      strobe_q <= cmd_i.emit_sign || cmd_i.emit_digit;
      if (cmd_i.load) begin
        idx_q  <= '0;
        bcnt_q <= '0;
        nd_q   <= '0;
      end
      if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.div) begin
        bcnt_q <= bcnt_q + 1'b1;
        if (&bcnt_q) begin
          nd_q <= nd_q + 1'b1;
        end
      end
      if (cmd_i.emit_digit) begin
        nd_q <= nd_m1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_i[VALUE_W-1];
      mag_q <= value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;
      rem_q <= '0;
    end
    if (cmd_i.scan) begin
      if (lk_byte == CHAR_NUL) begin
        radix_q <= RADIX_W'(idx_q);
      end else begin
        radix_q <= RADIX_W'(MAX_SYMBOLS);
      end
    end
    if (cmd_i.div) begin
      mag_q <= mag_d;
      if (&bcnt_q) begin
        stack_q[nd_q[DIGIT_IDX_W-1:0]] <= rem_d;
        rem_q                          <= '0;
      end else begin
        rem_q <= rem_d;
      end
    end
    if (cmd_i.emit_sign) begin
      sym_q  <= CHAR_MINUS;
      last_q <= 1'b0;
    end
    if (cmd_i.emit_digit) begin
      sym_q  <= lk_byte;
      last_q <= (nd_q == ND_W'(1));
    end
  end

  assign symbol_o = sym_q;
  assign last_o   = last_q;
  assign strobe_o = strobe_q;

endmodule

// ===== design/signed_int_to_radix_symbols.sv =====
// Top level of the signed integer to radix symbol converter.
// Depends on sirs_pkg, sirs_ctrl and sirs_dp.
//
// Usage: pulse start_i with value_i while busy_o is low; that edge accepts the
// transaction. The block then checks the alphabet held in the eight symbol
// registers (cfg_we_i / cfg_idx_i / cfg_wdata_i, write only while busy_o is
// low), divides the magnitude by the radix one quotient bit per cycle and
// sends the characters most significant first on symbol_o, each valid for
// one cycle with strobe_o high; last_o marks the final one. A negative value
// is led by '-'. An invalid alphabet ends the transaction with no output.
// After the last division step the controller enters the sign or output
// state, and the first character is then registered onto symbol_o. A single
// shared bit-serial divider computes every digit. The receiver cannot stall;
// results are never held.
// Reset loads the decimal alphabet "0123456789" and returns to idle.
module signed_int_to_radix_symbols import sirs_pkg::*; #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  output logic [SYM_W-1:0]     symbol_o,
  output logic                 last_o,
  output logic                 strobe_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sirs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  sirs_dp #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .value_i    (VALUE_W'(unsigned'(value_i))),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .symbol_o   (symbol_o),
    .last_o     (last_o),
    .strobe_o   (strobe_o)
  );

endmodule
